/* hw/rtl/mos6502_alu_top_assert.svh */
// Assertion macros used by the ALU top level.
`ifndef MOS6502_ALU_TOP_ASSERT_SVH
`define MOS6502_ALU_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MOS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mos6502_pkg.sv */
// Package: operation codes, BCD constants and stage payload types of the ALU.
package mos6502_pkg;

    localparam logic [3:0] MODE_ADD  = 4'd0;
    localparam logic [3:0] MODE_SUB  = 4'd1;
    localparam logic [3:0] MODE_INC  = 4'd2;
    localparam logic [3:0] MODE_DEC  = 4'd3;
    localparam logic [3:0] MODE_AND  = 4'd4;
    localparam logic [3:0] MODE_OR   = 4'd5;
    localparam logic [3:0] MODE_EOR  = 4'd6;
    localparam logic [3:0] MODE_ROL  = 4'd7;
    localparam logic [3:0] MODE_ROR  = 4'd8;
    localparam logic [3:0] MODE_ASL  = 4'd9;
    localparam logic [3:0] MODE_LSR  = 4'd10;
    localparam logic [3:0] MODE_BIT  = 4'd11;
    localparam logic [3:0] MODE_CMP  = 4'd12;
    localparam logic [3:0] MODE_LOAD = 4'd13;

    localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;
    localparam logic [3:0] BCD_ADJ       = 4'h6;
    localparam logic [7:0] BCD_ADJ_HI    = 8'h60;

    // Stage 1 -> stage 2: binary sum, raw low-nibble sums, simple result.
    typedef struct packed {
        logic [3:0] mode;
        logic [3:0] a_hi;
        logic [3:0] b_hi;
        logic       a7;
        logic       b7;
        logic       dec;
        logic       ov_in;
        logic [8:0] sum;
        logic       ov_bin;
        logic [4:0] lo_add;
        logic [5:0] lo_sub;
        logic [7:0] r_simple;
        logic       cy_simple;
        logic       ov_simple;
    } t_s1;

    // Stage 2 -> stage 3: final byte and flags before zero and sign.
    typedef struct packed {
        logic       is_bit;
        logic       b7;
        logic [7:0] r;
        logic       cy;
        logic       ov;
    } t_s2;

endpackage

/* hw/rtl/mos6502_front.sv */
// Stage 1: operand decode, binary adder, nibble sums and the simple operations.
module mos6502_front import mos6502_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  logic [3:0] i_mode,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    input  logic       i_carry_in,
    input  logic       i_decimal_in,
    input  logic       i_overflow_in,
    output logic       o_valid,
    output t_s1        o_data
);

    logic       r_valid;
    t_s1        r_data;
    t_s1        n_data;
    logic       is_inv;
    logic [7:0] b_op;
    logic       c_op;

    always_comb begin
        is_inv = i_mode inside {MODE_SUB, MODE_CMP};
        b_op   = is_inv ? ~i_operand_b : i_operand_b;
        c_op   = (i_mode == MODE_CMP) ? 1'b1 : i_carry_in;

        n_data.mode   = i_mode;
        n_data.a_hi   = i_operand_a[7:4];
        n_data.b_hi   = i_operand_b[7:4];
        n_data.a7     = i_operand_a[7];
        n_data.b7     = i_operand_b[7];
        n_data.dec    = i_decimal_in;
        n_data.ov_in  = i_overflow_in;
        n_data.sum    = {1'b0, i_operand_a} + {1'b0, b_op} + {8'd0, c_op};
        n_data.ov_bin = (i_operand_a[7] ^ n_data.sum[7]) & (b_op[7] ^ n_data.sum[7]);
        n_data.lo_add = {1'b0, i_operand_a[3:0]} + {1'b0, i_operand_b[3:0]}
                      + {4'd0, i_carry_in};
        // Two's complement in six bits; range is -16 to 15.
        n_data.lo_sub = {2'b00, i_operand_a[3:0]} - {2'b00, i_operand_b[3:0]}
                      + {5'd0, i_carry_in} - 6'd1;

        n_data.cy_simple = i_carry_in;
        n_data.ov_simple = i_overflow_in;
        case (i_mode)
            MODE_INC: n_data.r_simple = i_operand_a + 8'd1;
            MODE_DEC: n_data.r_simple = i_operand_a - 8'd1;
            MODE_AND: n_data.r_simple = i_operand_a & i_operand_b;
            MODE_OR:  n_data.r_simple = i_operand_a | i_operand_b;
            MODE_EOR: n_data.r_simple = i_operand_a ^ i_operand_b;
            MODE_ROL: begin
                n_data.r_simple  = {i_operand_a[6:0], i_carry_in};
                n_data.cy_simple = i_operand_a[7];
            end
            MODE_ROR: begin
                n_data.r_simple  = {i_carry_in, i_operand_a[7:1]};
                n_data.cy_simple = i_operand_a[0];
            end
            MODE_ASL: begin
                n_data.r_simple  = {i_operand_a[6:0], 1'b0};
                n_data.cy_simple = i_operand_a[7];
            end
            MODE_LSR: begin
                n_data.r_simple  = {1'b0, i_operand_a[7:1]};
                n_data.cy_simple = i_operand_a[0];
            end
            MODE_BIT: begin
                n_data.r_simple  = i_operand_a & i_operand_b;
                n_data.ov_simple = i_operand_b[6];
            end
            default:  n_data.r_simple = i_operand_a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* hw/rtl/mos6502_bcd.sv */
// Stage 2: decimal adjust for add and subtract, result and carry selection.
module mos6502_bcd import mos6502_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_s1  i_data,
    output logic o_valid,
    output t_s2  o_data
);

    logic       r_valid;
    t_s2        r_data;
    t_s2        n_data;
    logic [5:0] lo_adj;
    logic       lo_cy;
    logic [4:0] hi_sum;
    logic [5:0] hi_adj;
    logic       ov_dec;
    logic [7:0] r_add_dec;
    logic       cy_add_dec;
    logic [5:0] lo_fix;
    logic [9:0] whole;
    logic [7:0] r_sub_dec;

    always_comb begin
        // Add: adjust each nibble by six when it passes nine.
        lo_adj = (i_data.lo_add > {1'b0, BCD_MAX_DIGIT}) ?
                 ({1'b0, i_data.lo_add} + {2'b00, BCD_ADJ}) : {1'b0, i_data.lo_add};
        lo_cy  = (lo_adj > 6'd15);
        hi_sum = {1'b0, i_data.a_hi} + {1'b0, i_data.b_hi} + {4'd0, lo_cy};
        ov_dec = ~(i_data.a7 ^ i_data.b7) & (i_data.a7 ^ hi_sum[3]);
        hi_adj = (hi_sum > {1'b0, BCD_MAX_DIGIT}) ?
                 ({1'b0, hi_sum} + {2'b00, BCD_ADJ}) : {1'b0, hi_sum};
        cy_add_dec = (hi_adj > 6'd15);
        r_add_dec  = {hi_adj[3:0], lo_adj[3:0]};

        // Subtract: on a low borrow keep the nibble minus six, still negative.
        lo_fix = i_data.lo_sub[5] ? {2'b11, i_data.lo_sub[3:0] - BCD_ADJ} : i_data.lo_sub;
        whole  = {2'b00, i_data.a_hi, 4'd0} - {2'b00, i_data.b_hi, 4'd0}
               + {{4{lo_fix[5]}}, lo_fix};
        r_sub_dec = whole[9] ? (whole[7:0] - BCD_ADJ_HI) : whole[7:0];

        n_data.is_bit = (i_data.mode == MODE_BIT);
        n_data.b7     = i_data.b7;
        case (i_data.mode)
            MODE_ADD: begin
                n_data.r  = i_data.dec ? r_add_dec  : i_data.sum[7:0];
                n_data.cy = i_data.dec ? cy_add_dec : i_data.sum[8];
                n_data.ov = i_data.dec ? ov_dec     : i_data.ov_bin;
            end
            MODE_SUB: begin
                n_data.r  = i_data.dec ? r_sub_dec : i_data.sum[7:0];
                n_data.cy = i_data.sum[8];
                n_data.ov = i_data.ov_bin;
            end
            MODE_CMP: begin
                n_data.r  = i_data.sum[7:0];
                n_data.cy = i_data.sum[8];
                n_data.ov = i_data.ov_in;
            end
            default: begin
                n_data.r  = i_data.r_simple;
                n_data.cy = i_data.cy_simple;
                n_data.ov = i_data.ov_simple;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* hw/rtl/mos6502_flags.sv */
// Stage 3: zero and sign flags and the output register.
module mos6502_flags import mos6502_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_s2        i_data,
    output logic       o_valid,
    output logic [7:0] o_result,
    output logic       o_carry_out,
    output logic       o_zero_out,
    output logic       o_sign_out,
    output logic       o_overflow_out
);

    logic       r_valid;
    logic [7:0] r_result;
    logic       r_carry;
    logic       r_zero;
    logic       r_sign;
    logic       r_overflow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result   <= i_data.r;
            r_carry    <= i_data.cy;
            r_zero     <= (i_data.r == 8'd0);
            r_sign     <= i_data.is_bit ? i_data.b7 : i_data.r[7];
            r_overflow <= i_data.ov;
        end
    end

    assign o_valid        = r_valid;
    assign o_result       = r_result;
    assign o_carry_out    = r_carry;
    assign o_zero_out     = r_zero;
    assign o_sign_out     = r_sign;
    assign o_overflow_out = r_overflow;

endmodule

/* hw/rtl/mos6502_alu_top.sv */
// Top level of the pipelined 6502 ALU: three stages with valid/stall flow control.
//
// Input channel: i_valid with the operation fields; the block drives o_stall.
// An item is taken at a clock edge where i_valid is high and o_stall is low.
// Output channel: o_valid with the result and flags; the receiver drives
// i_stall. A result is taken where o_valid is high and i_stall is low.
// An item passes through the three register stages in order; o_valid rises once
// it reaches the flag stage, and its result is taken where i_stall is low.
// Without stalls from the receiver, one item can enter every cycle, one per clock.
// The stages are decode and binary add, BCD adjust, flag generation.
// Each stage advances when it is empty or when the stage after it advances,
// so bubbles collapse and a stall from the receiver backs up one stage at a
// time; o_stall rises only when all three stages hold items.
// Reset (synchronous, active low) clears the stage valid bits; payload
// registers keep whatever they hold.
module mos6502_alu_top import mos6502_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [3:0] i_mode,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    input  logic       i_carry_in,
    input  logic       i_decimal_in,
    input  logic       i_overflow_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_result,
    output logic       o_carry_out,
    output logic       o_zero_out,
    output logic       o_sign_out,
    output logic       o_overflow_out
);

`include "mos6502_alu_top_assert.svh"

    logic v1;
    logic v2;
    logic adv1;
    logic adv2;
    logic adv3;
    t_s1  s1_data;
    t_s2  s2_data;

    // Advance a stage when it is empty or its successor moves on.
    assign adv3    = !o_valid || !i_stall;
    assign adv2    = !v2 || adv3;
    assign adv1    = !v1 || adv2;
    assign o_stall = !adv1;

    mos6502_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (adv1),
        .i_valid       (i_valid),
        .i_mode        (i_mode),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .i_carry_in    (i_carry_in),
        .i_decimal_in  (i_decimal_in),
        .i_overflow_in (i_overflow_in),
        .o_valid       (v1),
        .o_data        (s1_data)
    );

    mos6502_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv2),
        .i_valid (v1),
        .i_data  (s1_data),
        .o_valid (v2),
        .o_data  (s2_data)
    );

    mos6502_flags u_flags (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (adv3),
        .i_valid        (v2),
        .i_data         (s2_data),
        .o_valid        (o_valid),
        .o_result       (o_result),
        .o_carry_out    (o_carry_out),
        .o_zero_out     (o_zero_out),
        .o_sign_out     (o_sign_out),
        .o_overflow_out (o_overflow_out)
    );

    // Back-pressure only with a full pipeline.
    `MOS_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_stall, v1 && v2 && o_valid, "not full")
    // A stalled result stays in the output stage.
    `MOS_ASSERT_NEXT(a_out_kept, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped")
    // A held middle item is not lost.
    `MOS_ASSERT_NEXT(a_mid_kept, i_clk, i_rst_n, v2 && !adv2, v2, "stage 2 item dropped")
    // Zero flag agrees with the delivered byte.
    `MOS_ASSERT_NOW(a_zero_ok, i_clk, i_rst_n, o_valid, o_zero_out == (o_result == 8'd0), "zero")

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the 6502 ALU: directed and random items against a local predictor.
`timescale 1ns / 100ps

module tb_top;
    import mos6502_pkg::*;

    // Modes 14 and 15 are not decoded by the block; they fall through to load.
    localparam logic [3:0] MODE_SPARE_LO = 4'd14;
    localparam logic [3:0] MODE_SPARE_HI = 4'd15;

    localparam int MAX_WAIT     = 18;   // longest idle drawn by either side
    localparam int RANDOM_ITEMS = 1100;
    localparam int DRAIN_LIMIT  = 5000; // cycles allowed for the pipe to empty
    localparam int TAIL_CYCLES  = 8;    // time to pass the three stages plus margin

    // One operation as it enters the block.
    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] a;
        logic [7:0] b;
        logic       carry;
        logic       dec;
        logic       ovf;
    } alu_op_t;

    // One result with its flags as it leaves the block.
    typedef struct packed {
        logic [7:0] value;
        logic       carry;
        logic       zero;
        logic       sign;
        logic       ovf;
    } alu_flags_t;

    // Holds the flags each accepted operation must produce, oldest first.
    class alu_result_book;
        alu_flags_t pending_flags[$];
        int         n_errors;
        int         n_ops;

        function new();
            n_errors = 0;
            n_ops    = 0;
        endfunction

        task report(string msg);
            n_errors++;
            // Keep the log short when the block is badly broken.
            if (n_errors <= 60)
                $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        // Work out the 6502 result byte and flags for one operation.
        function alu_flags_t alu_predict(alu_op_t op);
            alu_flags_t f;
            int a, b, c, sum, r, lo, hi, mid, whole, nb;
            a  = int'(op.a);
            b  = int'(op.b);
            c  = int'(op.carry);
            f.carry = op.carry;
            f.ovf   = op.ovf;
            case (op.mode)
                MODE_ADD: begin
                    if (!op.dec) begin
                        sum     = a + b + c;
                        r       = sum & 'hff;
                        f.carry = sum[8];
                        f.ovf   = (((a ^ r) & (b ^ r) & 'h80) != 0);
                    end else begin
                        // Decimal add: adjust each nibble by six once it passes nine.
                        lo = (a & 'h0f) + (b & 'h0f) + c;
                        if (lo > int'(BCD_MAX_DIGIT))
                            lo += int'(BCD_ADJ);
                        hi  = (a >> 4) + (b >> 4) + ((lo > 'h0f) ? 1 : 0);
                        mid = ((hi << 4) | (lo & 'h0f)) & 'hff;
                        // Overflow looks at the sum before the high nibble adjust.
                        f.ovf = (((~(a ^ b)) & (a ^ mid) & 'h80) != 0);
                        if (hi > int'(BCD_MAX_DIGIT))
                            hi += int'(BCD_ADJ);
                        f.carry = (hi > 'h0f);
                        r       = ((hi << 4) | (lo & 'h0f)) & 'hff;
                    end
                end
                MODE_SUB: begin
                    // Carry and overflow always come from the binary difference.
                    nb      = (~b) & 'hff;
                    sum     = a + nb + c;
                    r       = sum & 'hff;
                    f.carry = sum[8];
                    f.ovf   = (((a ^ r) & (nb ^ r) & 'h80) != 0);
                    if (op.dec) begin
                        lo = (a & 'h0f) - (b & 'h0f) + c - 1;
                        if (lo < 0)
                            lo = ((lo - int'(BCD_ADJ)) & 'h0f) - 'h10;
                        whole = (a & 'hf0) - (b & 'hf0) + lo;
                        if (whole < 0)
                            whole -= int'(BCD_ADJ_HI);
                        r = whole & 'hff;
                    end
                end
                MODE_INC: r = (a + 1) & 'hff;
                MODE_DEC: r = (a + 'hff) & 'hff;
                MODE_AND: r = a & b;
                MODE_OR:  r = a | b;
                MODE_EOR: r = a ^ b;
                MODE_ROL: begin
                    r       = ((a << 1) | c) & 'hff;
                    f.carry = op.a[7];
                end
                MODE_ROR: begin
                    r       = (a >> 1) | (c << 7);
                    f.carry = op.a[0];
                end
                MODE_ASL: begin
                    r       = (a << 1) & 'hff;
                    f.carry = op.a[7];
                end
                MODE_LSR: begin
                    r       = a >> 1;
                    f.carry = op.a[0];
                end
                MODE_BIT: begin
                    r     = a & b;
                    f.ovf = op.b[6];
                end
                MODE_CMP: begin
                    r       = (a + ((~b) & 'hff) + 1) & 'hff;
                    f.carry = (a >= b);
                end
                default: r = a;
            endcase
            f.value = r[7:0];
            f.zero  = (r[7:0] == 8'h00);
            f.sign  = (op.mode == MODE_BIT) ? op.b[7] : r[7];
            return f;
        endfunction

        function void note_input(alu_op_t op);
            pending_flags.push_back(alu_predict(op));
            n_ops++;
        endfunction

        task check_result(alu_flags_t got);
            alu_flags_t want;
            if (pending_flags.size() == 0) begin
                report($sformatf("result %02h with no operation outstanding", got.value));
                return;
            end
            want = pending_flags.pop_front();
            if (got.value !== want.value)
                report($sformatf("result: got %02h want %02h", got.value, want.value));
            if (got.carry !== want.carry)
                report($sformatf("carry: got %b want %b (result %02h)",
                                 got.carry, want.carry, want.value));
            if (got.zero !== want.zero)
                report($sformatf("zero: got %b want %b (result %02h)",
                                 got.zero, want.zero, want.value));
            if (got.sign !== want.sign)
                report($sformatf("sign: got %b want %b (result %02h)",
                                 got.sign, want.sign, want.value));
            if (got.ovf !== want.ovf)
                report($sformatf("overflow: got %b want %b (result %02h)",
                                 got.ovf, want.ovf, want.value));
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [3:0] i_mode;
    logic [7:0] i_operand_a;
    logic [7:0] i_operand_b;
    logic       i_carry_in;
    logic       i_decimal_in;
    logic       i_overflow_in;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_result;
    logic       o_carry_out;
    logic       o_zero_out;
    logic       o_sign_out;
    logic       o_overflow_out;

    alu_result_book book;
    int             ops_sent;
    int             results_seen;

    mos6502_alu_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_carry_in     (i_carry_in),
        .i_decimal_in   (i_decimal_in),
        .i_overflow_in  (i_overflow_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result       (o_result),
        .o_carry_out    (o_carry_out),
        .o_zero_out     (o_zero_out),
        .o_sign_out     (o_sign_out),
        .o_overflow_out (o_overflow_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Drop the run if the handshakes ever lock up.
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Draw an idle count; calm stretches run at full rate.
    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Present one item at the falling edge, hold it while the block stalls,
    // and log it with the predictor at the edge that takes it.
    task automatic drive_op(alu_op_t op);
        int gap;
        bit calm;
        // Run every third block of 150 items with no gaps at all.
        calm = ((ops_sent / 150) % 3 == 1);
        gap  = draw_wait(calm);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_mode        = op.mode;
        i_operand_a   = op.a;
        i_operand_b   = op.b;
        i_carry_in    = op.carry;
        i_decimal_in  = op.dec;
        i_overflow_in = op.ovf;
        i_valid       = 1'b1;
        do @(posedge i_clk); while (o_stall);
        book.note_input(op);
        ops_sent++;
    endtask

    task automatic send(logic [3:0] mode, logic [7:0] a, logic [7:0] b,
                        logic carry, logic dec, logic ovf);
        alu_op_t op;
        op = '{mode: mode, a: a, b: b, carry: carry, dec: dec, ovf: ovf};
        drive_op(op);
    endtask

    // Build a random item; lean on add and subtract, where the corner cases live.
    function automatic alu_op_t random_op();
        alu_op_t op;
        logic [7:0] corners[4];
        corners = '{8'h00, 8'hff, 8'h7f, 8'h80};
        op.mode  = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) < 3)
            op.mode = $urandom_range(0, 1) ? MODE_SUB : MODE_ADD;
        op.a     = 8'($urandom);
        op.b     = 8'($urandom);
        op.carry = 1'($urandom);
        op.dec   = 1'($urandom);
        op.ovf   = 1'($urandom);
        // Favor valid BCD digits in decimal mode, but keep raw bytes too.
        if (op.dec && $urandom_range(0, 2) != 0) begin
            op.a = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            op.b = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        end
        if ($urandom_range(0, 9) == 0)
            op.a = corners[$urandom_range(0, 3)];
        if ($urandom_range(0, 9) == 0)
            op.b = corners[$urandom_range(0, 3)];
        return op;
    endfunction

    // Receiver: stall for a drawn number of cycles, then take the next result.
    initial begin
        int wait_cycles;
        bit calm;
        alu_flags_t got;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            calm        = ((results_seen / 130) % 3 == 2);
            wait_cycles = draw_wait(calm);
            repeat (wait_cycles) begin
                @(negedge i_clk);
                i_stall = 1'b1;
            end
            @(negedge i_clk);
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
            got = '{value: o_result, carry: o_carry_out, zero: o_zero_out,
                    sign: o_sign_out, ovf: o_overflow_out};
            book.check_result(got);
            results_seen++;
        end
    end

    initial begin
        int drain;
        book          = new();
        ops_sent      = 0;
        results_seen  = 0;
        // Drive every input to a known value before the first edge.
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_mode        = MODE_LOAD;
        i_operand_a   = 8'h00;
        i_operand_b   = 8'h00;
        i_carry_in    = 1'b0;
        i_decimal_in  = 1'b0;
        i_overflow_in = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Binary add: carry out of the 9-bit sum, overflow set and cleared.
        send(MODE_ADD, 8'hff, 8'h01, 1'b1, 1'b0, 1'b1);
        send(MODE_ADD, 8'h7f, 8'h01, 1'b0, 1'b0, 1'b0);
        send(MODE_ADD, 8'h80, 8'h80, 1'b0, 1'b0, 1'b0);
        // Decimal add: both nibble adjusts, carry from the adjusted high nibble.
        send(MODE_ADD, 8'h99, 8'h01, 1'b0, 1'b1, 1'b0);
        send(MODE_ADD, 8'h58, 8'h46, 1'b1, 1'b1, 1'b1);
        send(MODE_ADD, 8'hff, 8'hff, 1'b1, 1'b1, 1'b0);
        // Subtract: binary overflow, full borrow, decimal borrow adjust.
        send(MODE_SUB, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0);
        send(MODE_SUB, 8'h00, 8'hff, 1'b0, 1'b0, 1'b1);
        send(MODE_SUB, 8'h00, 8'h01, 1'b1, 1'b1, 1'b0);
        send(MODE_SUB, 8'h46, 8'h12, 1'b1, 1'b1, 1'b1);
        // Increment and decrement wrap; flags other than zero and sign kept.
        send(MODE_INC, 8'hff, 8'h00, 1'b1, 1'b1, 1'b1);
        send(MODE_DEC, 8'h00, 8'hff, 1'b0, 1'b0, 1'b0);
        send(MODE_AND, 8'hff, 8'h00, 1'b1, 1'b0, 1'b1);
        send(MODE_OR,  8'h00, 8'hff, 1'b0, 1'b1, 1'b0);
        send(MODE_EOR, 8'hff, 8'hff, 1'b1, 1'b0, 1'b0);
        // Rotates feed carry in; shifts fill with zero; all take carry out.
        send(MODE_ROL, 8'h80, 8'h00, 1'b1, 1'b0, 1'b1);
        send(MODE_ROR, 8'h01, 8'h00, 1'b1, 1'b0, 1'b0);
        send(MODE_ASL, 8'h80, 8'h00, 1'b0, 1'b1, 1'b0);
        send(MODE_LSR, 8'h01, 8'h00, 1'b1, 1'b0, 1'b1);
        // Bit test: sign and overflow from operand b, zero from the AND.
        send(MODE_BIT, 8'h3f, 8'hc0, 1'b0, 1'b0, 1'b0);
        send(MODE_BIT, 8'hff, 8'h3f, 1'b1, 1'b0, 1'b1);
        // Compare: equal and below.
        send(MODE_CMP, 8'h42, 8'h42, 1'b0, 1'b1, 1'b0);
        send(MODE_CMP, 8'h00, 8'hff, 1'b1, 1'b0, 1'b1);
        // Load and the two undecoded modes that behave as load.
        send(MODE_LOAD,     8'h00, 8'hff, 1'b1, 1'b1, 1'b1);
        send(MODE_SPARE_LO, 8'h80, 8'h00, 1'b0, 1'b0, 1'b0);
        send(MODE_SPARE_HI, 8'hff, 8'h00, 1'b1, 1'b1, 1'b0);

        repeat (RANDOM_ITEMS) drive_op(random_op());
        @(negedge i_clk);
        i_valid = 1'b0;

        // Wait for every outstanding result, then let the pipe settle.
        drain = 0;
        while (book.pending_flags.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.pending_flags.size() != 0)
            book.report($sformatf("%0d results never arrived",
                                  book.pending_flags.size()));

        if (book.n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
